// ===== rtl/dkm_pkg.sv =====
// Shared constants, link and state types for the k-mismatch window search.
package dkm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int MAX_READ    = 1024;

   localparam int CODE_W  = 3;
   localparam int BASE_W  = 2;
   localparam int NBASES  = 4;
   localparam int POS_W   = 11;
   localparam int CSR_W   = 64;
   localparam int ADDR_W  = 5;
   localparam int LEN_W   = 6;
   localparam int PAT_BASES = CSR_W / BASE_W;
   localparam int PIDX_W  = $clog2(PAT_BASES);
   localparam int LEN_CAP = (MAX_PATTERN < PAT_BASES) ? MAX_PATTERN : PAT_BASES;
   localparam int RUN_W   = $clog2(LEN_CAP + 1);
   localparam int SUM_W   = RUN_W + 2;
   localparam int SEEN_W  = $clog2(MAX_READ + 1);
   localparam int ITER_COUNT = MAX_PATTERN + 2;
   localparam int ITER_W  = $clog2(ITER_COUNT + 1);

   localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

   localparam logic [1:0] REG_PATTERN_BASES  = 2'd0;
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
   localparam logic [1:0] REG_MAX_MISMATCHES = 2'd2;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic [CODE_W-1:0]             code;
      logic [RUN_W-1:0]              run;
      logic [NBASES-1:0][RUN_W-1:0]  mx;
      logic [RUN_W-1:0]              cnt;
   } link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAT,
      ST_EVAL,
      ST_JUDGE,
      ST_MATCH,
      ST_SUM
   } state_type;

endpackage

// ===== rtl/dkm_cell.sv =====
// One window cell: holds a base, relaxes run length, per-base max and mismatch count.
module dkm_cell
   import dkm_pkg::*;
(
   input  logic              clock,
   input  logic              shift,
   input  logic [CODE_W-1:0] win_in,
   output logic [CODE_W-1:0] win_out,
   input  logic              start,
   input  logic              mode_pat,
   input  logic              active,
   input  logic [BASE_W-1:0] pat_code,
   input  logic [BASE_W-1:0] cmp_code,
   input  link_type          left,
   output link_type          right
);

   logic [CODE_W-1:0]            win_ff;
   logic [RUN_W-1:0]             run_ff, run_in;
   logic [NBASES-1:0][RUN_W-1:0] mx_ff, mx_in;
   logic [RUN_W-1:0]             cnt_ff, cnt_in;
   logic [CODE_W-1:0]            ecode;
   logic                         valid;
   logic                         miss;

   always_comb begin
      ecode = mode_pat ? {1'b0, pat_code} : win_ff;
      valid = active && !ecode[CODE_W-1];
      miss  = active && !mode_pat && (ecode != {1'b0, cmp_code});
      if (!valid) begin
         run_in = '0;
      end else if (left.code == ecode) begin
         run_in = left.run + RUN_W'(1);
      end else begin
         run_in = RUN_W'(1);
      end
      for (int b = 0; b < NBASES; b++) begin
         if (valid && (ecode[BASE_W-1:0] == BASE_W'(b)) && (run_ff > left.mx[b])) begin
            mx_in[b] = run_ff;
         end else begin
            mx_in[b] = left.mx[b];
         end
      end
      cnt_in = left.cnt + RUN_W'(miss);
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         win_ff <= win_in;
      end
      if (start) begin
         run_ff <= '0;
         mx_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         mx_ff  <= mx_in;
         cnt_ff <= cnt_in;
      end
   end

   assign win_out    = win_ff;
   assign right.code = valid ? ecode : CODE_OTHER;
   assign right.run  = run_ff;
   assign right.mx   = mx_ff;
   assign right.cnt  = cnt_ff;

endmodule

// ===== rtl/dkm_cell_row.sv =====
// Row of window cells; newest base enters cell 0, results leave the last cell.
module dkm_cell_row
   import dkm_pkg::*;
(
   input  logic              clock,
   input  logic              shift,
   input  logic [CODE_W-1:0] new_code,
   input  logic              start,
   input  logic              mode_pat,
   input  logic [CSR_W-1:0]  pattern,
   input  logic [LEN_W-1:0]  eff_len,
   output link_type          result
);

   logic [MAX_PATTERN-1:0][CODE_W-1:0] win;
   link_type                           links [MAX_PATTERN+1];

   assign links[0] = '{code: CODE_OTHER, run: '0, mx: '0, cnt: '0};

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      localparam int PJ = j % PAT_BASES;
      logic [LEN_W-1:0]  rev;
      logic [BASE_W-1:0] cmp;
      logic [CODE_W-1:0] src;

      // Window slot j holds the base that lines up with pattern base len-1-j.
      assign rev = eff_len - LEN_W'(1) - LEN_W'(j);
      assign cmp = pattern[{rev[PIDX_W-1:0], 1'b0} +: BASE_W];

      if (j == 0) begin : g_head
         assign src = new_code;
      end else begin : g_body
         assign src = win[j-1];
      end

      dkm_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .win_in   (src),
         .win_out  (win[j]),
         .start    (start),
         .mode_pat (mode_pat),
         .active   (int'(eff_len) > j),
         .pat_code (pattern[2*PJ +: BASE_W]),
         .cmp_code (cmp),
         .left     (links[j]),
         .right    (links[j+1])
      );
   end

   assign result = links[MAX_PATTERN];

endmodule

// ===== rtl/dna_k_mismatch_window_search_core.sv =====
// Top level: k-mismatch DNA window search with stream ports and register port.
//
// Bases enter on the req_ stream, one per request: base code in req_tdata,
// end of read on req_tlast. Results leave on the rsp_ stream: positions and
// match count in rsp_tdata, kind (match or end-of-read summary) in rsp_tuser,
// and rsp_tlast on the final result of a request.
// Each accepted base shifts into a row of MAX_PATTERN cells; the cells then
// relax run lengths, per-base longest runs and mismatch counts, one cell per
// cycle, and a base holds off the next request until that is done, through
// the judge step when the window is tested, through each result, and through
// any wait for a full output register.
// The judge step sums the four run differences and checks both limits.
// Reset clears counters and starts a pass that derives the pattern's longest
// runs; the same pass runs after a write of the pattern bases or length, and
// req_tready stays low meanwhile.
// One result register sits on the output: the core keeps working on a
// request while a result waits, and holds in its emit step only when the
// register is still full. Registers are read and written on the csr_ port.
module dna_k_mismatch_window_search_core
   import dkm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [2:0] base_code
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // [10:0] start_position, [21:11] end_position,
                                          // [32:22] matches_so_far
   output logic [0:0]        rsp_tuser,   // [0] item_kind
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   state_type state_ff, state_in;

   logic [CSR_W-1:0] pattern_ff;
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] maxmis_ff;
   logic             dirty_ff;
   logic             mode_pat_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [SEEN_W-1:0] seen_ff;
   logic [SEEN_W-1:0] total_ff;
   logic             test_ff;
   logic             last_ff;
   logic [NBASES-1:0][RUN_W-1:0] pat_runs_ff;

   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   logic [POS_W-1:0] rsp_start_ff;
   logic [POS_W-1:0] rsp_end_ff;
   logic [POS_W-1:0] rsp_count_ff;
   logic             rsp_last_ff;

   logic             wr;
   logic             wr_pat;
   logic [LEN_W-1:0] eff_len;
   logic             accept;
   logic             enter_pat;
   logic             start;
   logic             iter_done;
   logic             out_free;
   logic             load_match;
   logic             load_sum;
   logic             counted;
   logic [SEEN_W-1:0] seen_next;
   logic [SUM_W-1:0] run_diff;
   logic             is_match;
   link_type         row_out;

   // Register port
   assign csr_pready = 1'b1;
   assign wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_pat = wr && ((csr_paddr[4:3] == REG_PATTERN_BASES) ||
                          (csr_paddr[4:3] == REG_PATTERN_LENGTH));

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_PATTERN_BASES:  csr_prdata = pattern_ff;
         REG_PATTERN_LENGTH: csr_prdata = CSR_W'(length_ff);
         REG_MAX_MISMATCHES: csr_prdata = CSR_W'(maxmis_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(length_ff) > LEN_CAP) begin
         eff_len = LEN_W'(LEN_CAP);
      end else begin
         eff_len = length_ff;
      end
   end

   dkm_cell_row u_row (
      .clock    (clock),
      .shift    (accept),
      .new_code (req_tdata[CODE_W-1:0]),
      .start    (start),
      .mode_pat (mode_pat_ff),
      .pattern  (pattern_ff),
      .eff_len  (eff_len),
      .result   (row_out)
   );

   // Run signature distance against the pattern
   always_comb begin
      run_diff = '0;
      for (int b = 0; b < NBASES; b++) begin
         if (row_out.mx[b] > pat_runs_ff[b]) begin
            run_diff = run_diff + SUM_W'(row_out.mx[b] - pat_runs_ff[b]);
         end else begin
            run_diff = run_diff + SUM_W'(pat_runs_ff[b] - row_out.mx[b]);
         end
      end
      is_match = (run_diff <= SUM_W'(maxmis_ff)) && (row_out.cnt <= RUN_W'(maxmis_ff));
   end

   assign counted   = seen_ff < SEEN_W'(MAX_READ);
   assign seen_next = seen_ff + SEEN_W'(1);
   assign iter_done = iter_ff == ITER_W'(ITER_COUNT - 1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) begin
               state_in = ST_PAT;
            end else if (req_tvalid) begin
               state_in = ST_EVAL;
            end
         end
         ST_PAT: begin
            if (iter_done) state_in = ST_IDLE;
         end
         ST_EVAL: begin
            if (iter_done) begin
               priority if (test_ff) state_in = ST_JUDGE;
               else if (last_ff)     state_in = ST_SUM;
               else                  state_in = ST_IDLE;
            end
         end
         ST_JUDGE: begin
            priority if (is_match) state_in = ST_MATCH;
            else if (last_ff)      state_in = ST_SUM;
            else                   state_in = ST_IDLE;
         end
         ST_MATCH: begin
            if (out_free) state_in = last_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !dirty_ff;
      enter_pat  = (state_ff == ST_IDLE) && dirty_ff;
      accept     = req_tvalid && req_tready;
      start      = enter_pat || accept;
      load_match = (state_ff == ST_MATCH) && out_free;
      load_sum   = (state_ff == ST_SUM) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pattern_ff   <= '0;
         length_ff    <= LEN_W'(1);
         maxmis_ff    <= '0;
         dirty_ff     <= 1'b1;
         mode_pat_ff  <= 1'b1;
         iter_ff      <= '0;
         seen_ff      <= '0;
         total_ff     <= '0;
         test_ff      <= 1'b0;
         last_ff      <= 1'b0;
         pat_runs_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (wr && (csr_paddr[4:3] == REG_PATTERN_BASES))  pattern_ff <= csr_pwdata;
         if (wr && (csr_paddr[4:3] == REG_PATTERN_LENGTH)) length_ff  <= csr_pwdata[LEN_W-1:0];
         if (wr && (csr_paddr[4:3] == REG_MAX_MISMATCHES)) maxmis_ff  <= csr_pwdata[LEN_W-1:0];

         // A write landing during a derive pass leaves the flag set for a rerun.
         if (wr_pat) begin
            dirty_ff <= 1'b1;
         end else if (enter_pat) begin
            dirty_ff <= 1'b0;
         end

         if (enter_pat) begin
            mode_pat_ff <= 1'b1;
         end else if (accept) begin
            mode_pat_ff <= 1'b0;
         end

         if (start) begin
            iter_ff <= '0;
         end else if ((state_ff == ST_PAT) || (state_ff == ST_EVAL)) begin
            iter_ff <= iter_ff + ITER_W'(1);
         end

         if ((state_ff == ST_PAT) && iter_done) begin
            pat_runs_ff <= row_out.mx;
         end

         if (accept) begin
            if (counted) seen_ff <= seen_next;
            test_ff <= counted && (seen_next >= SEEN_W'(eff_len));
            last_ff <= req_tlast;
         end

         if ((state_ff == ST_JUDGE) && is_match && (total_ff < SEEN_W'(MAX_READ))) begin
            total_ff <= total_ff + SEEN_W'(1);
         end

         if (load_sum) begin
            seen_ff  <= '0;
            total_ff <= '0;
         end

         if (load_match || load_sum) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (load_match) begin
         rsp_kind_ff  <= KIND_MATCH;
         rsp_start_ff <= POS_W'(seen_ff - SEEN_W'(eff_len) + SEEN_W'(1));
         rsp_end_ff   <= POS_W'(seen_ff);
         rsp_count_ff <= POS_W'(total_ff);
         rsp_last_ff  <= !last_ff;
      end else if (load_sum) begin
         rsp_kind_ff  <= KIND_SUMMARY;
         rsp_start_ff <= '0;
         rsp_end_ff   <= '0;
         rsp_count_ff <= POS_W'(total_ff);
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_end_ff, rsp_start_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_accept_while_dirty: assert property (@(posedge clock) disable iff (reset)
      accept |-> !dirty_ff)
      else $error("request accepted before pattern runs were derived");

   a_match_has_count: assert property (@(posedge clock) disable iff (reset)
      load_match |-> (total_ff != '0))
      else $error("match report with zero match count");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_READ))
      else $error("base counter past read limit");

   a_match_positions: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_MATCH)) |->
         ((rsp_start_ff != '0) && (rsp_start_ff <= rsp_end_ff)))
      else $error("match report with bad window positions");

   a_summary_after_clear: assert property (@(posedge clock) disable iff (reset)
      load_sum |=> ((seen_ff == '0) && (total_ff == '0)))
      else $error("read counters not cleared after summary");

endmodule

// ===== tb/sv/dkm_search_checker.sv =====
// Checker for the k-mismatch window search: predicts results and compares them.
`timescale 1ns / 100ps
module dkm_search_checker
   import dkm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [39:0]       rsp_tdata,
   input  logic [0:0]        rsp_tuser,
   input  logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   input  logic              csr_pready,
   output int                error_count,
   output int                pending,
   output int                match_reports,
   output int                read_summaries
);

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [POS_W-1:0] found;
      logic             last;
   } hit_type;

   hit_type          hits_due[$];
   logic [CSR_W-1:0] pat_bits;
   logic [LEN_W-1:0] pat_len;
   logic [LEN_W-1:0] miss_limit;
   logic [CODE_W-1:0] window[MAX_PATTERN];
   int               seen;
   int               found_total;

   assign pending = hits_due.size();

   function automatic int active_length();
      int n;
      n = pat_len;
      if (n == 0) n = 1;
      if (n > LEN_CAP) n = LEN_CAP;
      return n;
   endfunction

   function automatic logic [1:0] pattern_at(int x);
      return pat_bits[2*x +: 2];
   endfunction

   // Longest same-base run per base; codes above 3 break any run.
   function automatic void base_runs(input logic [CODE_W-1:0] seq[MAX_PATTERN], input int n,
                                     output int runs[NBASES]);
      int cur;
      int prev;
      cur = 0;
      prev = 7;
      for (int b = 0; b < NBASES; b++) runs[b] = 0;
      for (int k = 0; k < n; k++) begin
         if (seq[k] > 3) begin
            cur = 0;
            prev = 7;
         end else begin
            cur = (seq[k] == prev) ? cur + 1 : 1;
            prev = seq[k];
            if (cur > runs[seq[k]]) runs[seq[k]] = cur;
         end
      end
   endfunction

   function automatic bit window_hits(int n);
      logic [CODE_W-1:0] wseq[MAX_PATTERN];
      logic [CODE_W-1:0] pseq[MAX_PATTERN];
      int wr[NBASES];
      int pr[NBASES];
      int run_gap;
      int ham;
      run_gap = 0;
      ham = 0;
      for (int x = 0; x < MAX_PATTERN; x++) begin
         wseq[x] = (x < n) ? window[n-1-x] : '0;
         pseq[x] = {1'b0, pattern_at(x)};
      end
      base_runs(wseq, n, wr);
      base_runs(pseq, n, pr);
      for (int b = 0; b < NBASES; b++)
         run_gap += (wr[b] > pr[b]) ? wr[b] - pr[b] : pr[b] - wr[b];
      if (run_gap > miss_limit) return 0;
      for (int x = 0; x < n; x++) if (wseq[x] != pseq[x]) ham++;
      return ham <= miss_limit;
   endfunction

   task automatic take_base(logic [CODE_W-1:0] code, logic fin);
      int n;
      int made;
      hit_type h;
      n = active_length();
      made = 0;
      for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = code;
      if (seen < MAX_READ) begin
         seen++;
         if (seen >= n && window_hits(n)) begin
            if (found_total < MAX_READ) found_total++;
            h = '{KIND_MATCH, POS_W'(seen - n + 1), POS_W'(seen), POS_W'(found_total), 1'b0};
            hits_due.push_back(h);
            made++;
         end
      end
      if (fin) begin
         h = '{KIND_SUMMARY, '0, '0, POS_W'(found_total), 1'b1};
         hits_due.push_back(h);
         seen = 0;
         found_total = 0;
      end else if (made > 0) begin
         hits_due[hits_due.size()-1].last = 1'b1;
      end
   endtask

   task automatic flag(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (error_count < 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      hit_type h;
      if (reset) begin
         pat_bits <= '0;
         pat_len <= LEN_W'(1);
         miss_limit <= '0;
         seen = 0;
         found_total = 0;
         hits_due.delete();
         error_count = 0;
         match_reports <= 0;
         read_summaries <= 0;
      end else begin
         if (req_tvalid && req_tready) take_base(req_tdata[CODE_W-1:0], req_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               REG_PATTERN_BASES:  pat_bits <= csr_pwdata;
               REG_PATTERN_LENGTH: pat_len <= csr_pwdata[LEN_W-1:0];
               REG_MAX_MISMATCHES: miss_limit <= csr_pwdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (hits_due.size() == 0) begin
               if (error_count < 10) $display("%0t: result with none expected", $realtime);
               error_count++;
            end else begin
               h = hits_due.pop_front();
               if (rsp_tuser[0] != h.kind)
                  flag("kind", POS_W'(h.kind), POS_W'(rsp_tuser[0]));
               if (rsp_tdata[10:0] != h.start_pos) flag("start", h.start_pos, rsp_tdata[10:0]);
               if (rsp_tdata[21:11] != h.end_pos) flag("end", h.end_pos, rsp_tdata[21:11]);
               if (rsp_tdata[32:22] != h.found) flag("count", h.found, rsp_tdata[32:22]);
               if (rsp_tlast != h.last) flag("tlast", POS_W'(h.last), POS_W'(rsp_tlast));
               if (h.kind == KIND_MATCH) match_reports <= match_reports + 1;
               else read_summaries <= read_summaries + 1;
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, configuration writes and verdict for the window search.
`timescale 1ns / 100ps
module tb;
   import dkm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;   // [2:0] base_code
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [39:0]       rsp_tdata;        // [10:0] start, [21:11] end, [32:22] matches
   logic [0:0]        rsp_tuser;        // [0] item_kind
   logic              rsp_tlast;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_W-1:0]  csr_pwdata = '0;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   int error_count, pending, match_reports, read_summaries;
   int send_idle, recv_idle, cycles;
   logic [CSR_W-1:0] cur_pattern;
   int cur_len;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dna_k_mismatch_window_search_core DUT (.*);

   dkm_search_checker u_checker (.*);

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_base(logic [CODE_W-1:0] code, logic fin);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, code};
      req_tlast <= fin;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
   endtask

   // Drain outstanding results and let the core settle before a register write.
   task automatic drain();
      req_tvalid <= 1'b0;
      forever begin
         @(negedge clock);
         if (pending == 0) break;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [CSR_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(logic [CSR_W-1:0] pat, logic [LEN_W-1:0] len,
                            logic [LEN_W-1:0] limit);
      drain();
      csr_write(REG_PATTERN_BASES, pat);
      csr_write(REG_PATTERN_LENGTH, len);
      csr_write(REG_MAX_MISMATCHES, limit);
      cur_pattern = pat;
      cur_len = (len == 0) ? 1 : (len > LEN_CAP ? LEN_CAP : len);
   endtask

   // One read: mostly a planted, lightly mutated pattern copy in random filler.
   task automatic send_read(int nbases);
      int off;
      bit planted;
      logic [CODE_W-1:0] c;
      planted = ($urandom_range(99) < 80);
      off = $urandom_range(0, (nbases > cur_len) ? nbases - cur_len : 0);
      for (int i = 0; i < nbases; i++) begin
         if (planted && i >= off && i < off + cur_len && $urandom_range(99) >= 10)
            c = {1'b0, cur_pattern[2*(i-off) +: 2]};
         else if ($urandom_range(99) < 85)
            c = CODE_W'($urandom_range(0, 3));
         else
            c = CODE_W'($urandom_range(4, 7));
         send_base(c, i == nbases - 1);
      end
   endtask

   initial begin
      logic [LEN_W-1:0] lens[9] = '{1, 2, 4, 8, 12, 32, 0, 40, 63};
      logic [LEN_W-1:0] limits[6] = '{0, 1, 2, 3, 32, 63};
      int sent;
      logic [CSR_W-1:0] pat;
      send_idle = 0;
      recv_idle = 0;
      cur_pattern = '0;
      cur_len = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset pattern is a single A: each base, other codes, a one-base read.
      send_base(0, 0); send_base(1, 0); send_base(3, 0);
      send_base(2, 0); send_base(4, 0); send_base(7, 1);
      send_base(0, 1);
      // Exact, mutated and other-base windows of ATGC with zero tolerance.
      configure(64'hE4, 4, 0);
      csr_write(2'd3, 64'hFFFF);   // beyond the register list
      send_base(0, 0); send_base(1, 0); send_base(2, 0); send_base(3, 0);
      send_base(0, 0); send_base(1, 0); send_base(5, 0); send_base(3, 1);
      // Full length, all-ones pattern, widest tolerance; length 0 acts as 1.
      configure('1, 32, 63);
      for (int i = 0; i < 3; i++) send_base(6, i == 2);
      configure(64'h0, 0, 32);
      send_base(3, 0); send_base(0, 1);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 11 : (mode == 1) ? 80 : 0;
         recv_idle = (mode == 0) ? 80 : (mode == 1) ? 11 : 0;
         for (int sub = 0; sub < 4; sub++) begin
            case ($urandom_range(0, 3))
               0: pat = '0;
               1: pat = '1;
               default: pat = {$urandom, $urandom};
            endcase
            configure(pat, lens[$urandom_range(0, 8)], limits[$urandom_range(0, 5)]);
            sent = 0;
            while (sent < 52) begin
               int n;
               n = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : $urandom_range(4, 40);
               send_read(n);
               sent += n;
            end
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Covered %0d match reports and %0d read summaries", match_reports,
               read_summaries);
      $display("over several pattern lengths, tolerances and stall patterns");
      if (error_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
